FILE: hw/rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg - shared types and constants of the base64 stream encoder
// Group descriptor passed from front to back, alphabet lookup, pad code.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0] PAD_CHAR = 7'h3D;	// '='

	// one group of up to three bytes, waiting to be turned into four characters
	typedef struct packed {
		logic [23:0] word;		// first byte in the top bits
		logic [1:0]  pad_count;	// trailing '=' characters (0..2)
		logic        last;		// group closes the message
	} group_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [6:0] b64_char(input logic [5:0] sym);
		logic [6:0] ch;
		case (sym) inside
			[6'd0:6'd25]:  ch = 7'h41 + {1'b0, sym};
			[6'd26:6'd51]: ch = 7'h61 + {1'b0, sym} - 7'd26;
			[6'd52:6'd61]: ch = 7'h30 + {1'b0, sym} - 7'd52;
			6'd62:         ch = 7'h2B;
			default:       ch = 7'h2F;
		endcase
		return ch;
	endfunction

endpackage

FILE: hw/rtl/b64e_if.sv
// ----------------------------------------------------------------------------
// b64e_if - stream interfaces of the base64 stream encoder
// Byte stream in, character stream out, both valid/ready.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

FILE: hw/rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front - byte collector
// Gathers bytes into groups of three, closes short groups at end of message.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic             clk,
	input  logic             arst_n,
	b64e_byte_if.sink        byte_in,
	output logic             push,
	output b64e_pkg::group_t push_data,
	input  logic             push_ready
);
	import b64e_pkg::*;

	logic [15:0] pend_q;	// older byte in the high half
	logic [1:0]  cnt_q;
	logic        take;

	assign byte_in.ready = push_ready;
	assign take          = byte_in.valid & push_ready;
	// a count of three never arises; bit 1 alone marks a full pair
	assign push          = take & (cnt_q[1] | byte_in.end_of_message);

	always_comb begin
		push_data.last = byte_in.end_of_message;
		if (cnt_q[1]) begin
			push_data.word      = {pend_q, byte_in.data_byte};
			push_data.pad_count = 2'd0;
		end else if (cnt_q[0]) begin
			push_data.word      = {pend_q[7:0], byte_in.data_byte, 8'h00};
			push_data.pad_count = 2'd1;
		end else begin
			push_data.word      = {byte_in.data_byte, 16'h0000};
			push_data.pad_count = 2'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 16'h0000;
			cnt_q  <= 2'd0;
		end else if (take) begin
			if (push) begin
				pend_q <= 16'h0000;
				cnt_q  <= 2'd0;
			end else begin
				pend_q <= {pend_q[7:0], byte_in.data_byte};
				cnt_q  <= cnt_q + 2'd1;
			end
		end
	end

endmodule

FILE: hw/rtl/b64e_fifo.sv
// ----------------------------------------------------------------------------
// b64e_fifo - group queue
// Small register queue between collector and character sequencer.
// ----------------------------------------------------------------------------
module b64e_fifo #(
	parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64e_pkg::group_t push_data,
	output logic             push_ready,
	input  logic             pop,
	output b64e_pkg::group_t pop_data,
	output logic             pop_valid
);
	import b64e_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	group_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign push_ready = (cnt_q != CNT_FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_ready) else $error("group pushed into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid) else $error("group popped from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL) else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back - character sequencer
// Steps through a group's four characters into a registered output.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64e_pkg::group_t pop_data,
	input  logic             pop_valid,
	output logic             pop,
	b64e_char_if.source      char_out
);
	import b64e_pkg::*;

	group_t     cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;

	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       out_last_q;
	logic [1:0] out_pos_q;

	logic       adv;
	logic [5:0] sym;
	logic       is_pad;

	assign adv = cur_valid_q & (~out_valid_q | char_out.ready);
	assign pop = pop_valid & (~cur_valid_q | (adv & (idx_q == 2'd3)));

	always_comb begin
		case (idx_q)
			2'd0:    sym = cur_q.word[23:18];
			2'd1:    sym = cur_q.word[17:12];
			2'd2:    sym = cur_q.word[11:6];
			default: sym = cur_q.word[5:0];
		endcase
	end

	// pads take the tail positions of the group
	assign is_pad = ({1'b0, idx_q} + {1'b0, cur_q.pad_count}) > 3'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (adv) begin
			idx_q <= idx_q + 2'd1;
			if (idx_q == 2'd3) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
		if (adv) begin
			out_char_q <= is_pad ? PAD_CHAR : b64_char(sym);
			out_last_q <= cur_q.last & (idx_q == 2'd3);
			out_pos_q  <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (char_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign char_out.valid     = out_valid_q;
	assign char_out.out_char  = out_char_q;
	assign char_out.last_char = out_last_q;

	a_last_on_fourth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_pos_q == 2'd3))
		else $error("last flag away from fourth character");
	a_head_not_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_pos_q[1]) |-> (out_char_q != PAD_CHAR))
		else $error("pad in first half of group");
	a_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && idx_q != 2'd3) |=> cur_valid_q)
		else $error("group dropped before fourth character");

endmodule

FILE: hw/rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder - streaming base64 encoder, standard alphabet
// Bytes in, ASCII characters out, '=' padding on short final groups.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while the group queue has room; the output
// side delivers one character per cycle while the receiver is ready, so a
// steady stream runs at four characters per three bytes, its pace set by
// the single character port. A full group goes out as four characters, a
// message that ends on one or two spare bytes goes out as two or three
// characters plus '=' pads, with last_char high on the fourth character.
// A group's first character goes through queue, group and output registers.
// No output for a group until it is complete or closed by end_of_message.
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	b64e_byte_if.sink   byte_in,
	b64e_char_if.source char_out
);
	import b64e_pkg::*;

	// front -> queue
	logic   push;
	logic   push_ready;
	group_t push_data;

	// queue -> back
	logic   pop;
	logic   pop_valid;
	group_t pop_data;

	// collects bytes, closes groups
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// decouples byte intake from character output
	b64e_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid)
	);

	// four characters per group, registered output
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop       (pop),
		.char_out  (char_out)
	);

endmodule

FILE: test/b64e_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64e_stream_checker - scoreboard for the base64 stream encoder
// Watches both channels, predicts every character from the accepted bytes
// and compares each accepted character against the oldest prediction.
// ----------------------------------------------------------------------------
module b64e_stream_checker (
	input  logic  clk,
	input  logic  arst_n,
	b64e_byte_if  byte_ch,
	b64e_char_if  char_ch,
	output int    fail_count,
	output int    chars_waiting
);

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} char_exp_t;

	char_exp_t   expected_chars[$];
	logic [15:0] held_bytes;
	logic [1:0]  held_count;
	int          char_index;

	function automatic logic [6:0] sym_to_ascii(input logic [5:0] sym);
		logic [7:0] code;
		code = ALPHABET[8*(63 - sym) +: 8];
		return code[6:0];
	endfunction

	// four characters per group: n_sym coded, the rest padding
	task automatic queue_group(input logic [23:0] group, input int n_sym, input logic closes);
		char_exp_t e;
		for (int i = 0; i < 4; i++) begin
			e.ch   = (i < n_sym) ? sym_to_ascii(group[23 - 6*i -: 6]) : b64e_pkg::PAD_CHAR;
			e.last = closes && (i == 3);
			expected_chars = {expected_chars, e};
		end
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic eom);
		if (held_count == 2'd2) begin
			queue_group({held_bytes, b}, 4, eom);
			held_bytes = '0;
			held_count = '0;
		end else begin
			held_bytes = {held_bytes[7:0], b};
			held_count = held_count + 2'd1;
			if (eom) begin
				if (held_count == 2'd1)
					queue_group({held_bytes[7:0], 16'h0000}, 2, 1'b1);
				else
					queue_group({held_bytes, 8'h00}, 3, 1'b1);
				held_bytes = '0;
				held_count = '0;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			expected_chars.delete();
			held_bytes = '0;
			held_count = '0;
			char_index = 0;
			fail_count = 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				encode_byte(byte_ch.data_byte, byte_ch.end_of_message);
			if (char_ch.valid && char_ch.ready) begin
				if (expected_chars.size() == 0) begin
					if (fail_count < 10)
						$display("char %0d: unexpected 0x%02h last %0b", char_index,
							char_ch.out_char, char_ch.last_char);
					fail_count++;
				end else begin
					if (char_ch.out_char !== expected_chars[0].ch ||
							char_ch.last_char !== expected_chars[0].last) begin
						if (fail_count < 10)
							$display("char %0d: expected 0x%02h last %0b, got 0x%02h last %0b",
								char_index, expected_chars[0].ch, expected_chars[0].last,
								char_ch.out_char, char_ch.last_char);
						fail_count++;
					end
					void'(expected_chars.pop_front());
				end
				char_index++;
			end
		end
		chars_waiting = expected_chars.size();
	end

endmodule

FILE: test/base64_stream_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb - top level of the base64 encoder testbench
// Drives byte messages in bursts with random gaps, stalls the character
// side on a shifting pattern, and reports the scoreboard's verdict.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;

	// generous bound for a run of a few hundred bytes
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 180;
	// drain time after the last prediction is met
	localparam int DRAIN_CYCLES = 20;

	// receiver behaviour, each held for a random span of cycles
	typedef enum int {
		RX_OPEN,	// always ready, no stalls at all
		RX_COIN,	// ready half the time
		RX_SPARSE,	// ready one cycle in four
		RX_MOSTLY	// ready seven times in eight
	} rx_mode_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   chars_waiting;
	int   cycle_count;
	int   burst_left;
	int   bytes_sent;

	b64e_byte_if byte_ch();
	b64e_char_if char_ch();

	base64_stream_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_ch),
		.char_out (char_ch)
	);

	b64e_stream_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_ch       (byte_ch),
		.char_ch       (char_ch),
		.fail_count    (fail_count),
		.chars_waiting (chars_waiting)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung block or lost characters end up here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Send one byte. The sender works in bursts: when a burst runs out,
	// valid drops for a random gap (possibly none) and a new burst length
	// is drawn. Within a burst valid stays high from item to item.
	task automatic send_byte(input logic [7:0] b, input logic eom);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		byte_ch.valid          <= 1'b1;
		byte_ch.data_byte      <= b;
		byte_ch.end_of_message <= eom;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	// random byte, leaning now and then towards the all-zero and all-one extremes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// character side: ready follows a mode that changes every so often
	initial begin
		rx_mode_t mode;
		int       span;
		char_ch.ready <= 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 96);
			for (int tick = 0; tick < span; tick++) begin
				@(posedge clk);
				case (mode)
					RX_OPEN:   char_ch.ready <= 1'b1;
					RX_COIN:   char_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: char_ch.ready <= (tick % 4 == 0);
					default:   char_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		int msg_len;
		burst_left             = 0;
		bytes_sent             = 0;
		arst_n                 = 1'b0;
		byte_ch.valid          <= 1'b0;
		byte_ch.data_byte      <= 8'h00;
		byte_ch.end_of_message <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// single byte messages at both extremes: two characters and two pads
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// two byte message: three characters and one pad
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// full group closing the message, no padding
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b1);
		// hits both '+' and '/'
		send_byte(8'hFB, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hBF, 1'b1);
		// full group mid-message, then a full group to close
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// four bytes: one group then a one-byte tail
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h04, 1'b1);
		// five bytes: one group then a two-byte tail
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h3C, 1'b1);

		// random messages, mostly short, now and then a long one
		while (bytes_sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 7) == 0)
				msg_len = $urandom_range(10, 40);
			else
				msg_len = $urandom_range(1, 9);
			for (int i = 0; i < msg_len; i++)
				send_byte(pick_byte(), i == msg_len - 1);
		end

		byte_ch.valid <= 1'b0;
		// let the scoreboard take in the final byte before polling it
		@(posedge clk);
		while (chars_waiting != 0) @(posedge clk);
		// stray characters after the last one would show up here
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && chars_waiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_if.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_fifo.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
test/b64e_stream_checker.sv
test/base64_stream_encoder_tb.sv
